// ----- hw/rtl/qou_pkg.sv -----
`timescale 1ns / 1ps

package qou_pkg;

  // Default component format: signed Q1.14 in 16 bits.
  localparam int unsigned CompWidthDef = 16;
  localparam int unsigned FracBitsDef  = 14;

  // Request kinds carried on the input tuser.
  localparam logic FUNC_COMPOSE = 1'b0;
  localparam logic FUNC_ROTATE  = 1'b1;

  // Component positions inside a quaternion.
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HMUL0,
    ST_HMUL1,
    ST_SQ,
    ST_SQRT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } qou_state_e;

  // Control for one multiply-accumulate operation.
  typedef struct packed {
    logic valid;
    logic first;
    logic neg;
  } mac_ctrl_t;

  // One term of the Hamilton product: a[a_idx] * b[b_idx], optionally negated.
  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic       neg;
  } hmul_term_t;

  // Term schedule of the Hamilton product a * b; four terms per component,
  // components in x, y, z, w order.
  function automatic hmul_term_t hmul_term(input logic [3:0] step);
    hmul_term_t t;
    case (step)
      4'd0:    t = '{IDX_W, IDX_X, 1'b0};
      4'd1:    t = '{IDX_X, IDX_W, 1'b0};
      4'd2:    t = '{IDX_Y, IDX_Z, 1'b0};
      4'd3:    t = '{IDX_Z, IDX_Y, 1'b1};
      4'd4:    t = '{IDX_W, IDX_Y, 1'b0};
      4'd5:    t = '{IDX_X, IDX_Z, 1'b1};
      4'd6:    t = '{IDX_Y, IDX_W, 1'b0};
      4'd7:    t = '{IDX_Z, IDX_X, 1'b0};
      4'd8:    t = '{IDX_W, IDX_Z, 1'b0};
      4'd9:    t = '{IDX_X, IDX_Y, 1'b0};
      4'd10:   t = '{IDX_Y, IDX_X, 1'b1};
      4'd11:   t = '{IDX_Z, IDX_W, 1'b0};
      4'd12:   t = '{IDX_W, IDX_W, 1'b0};
      4'd13:   t = '{IDX_X, IDX_X, 1'b1};
      4'd14:   t = '{IDX_Y, IDX_Y, 1'b1};
      4'd15:   t = '{IDX_Z, IDX_Z, 1'b1};
      default: t = '{IDX_W, IDX_W, 1'b0};
    endcase
    return t;
  endfunction

endpackage

// ----- hw/rtl/quaternion_orientation_unit.sv -----
`timescale 1ns / 1ps

// Quaternion orientation unit. Holds one orientation quaternion in signed
// fixed point (COMP_WIDTH bits, FRAC_BITS fraction bits), reset to identity.
// A compose request (tuser 0) multiplies the stored quaternion by the operand,
// rounds, scales the product to unit length and stores and returns it; a zero
// product is stored and returned as is. A rotate request (tuser 1) returns the
// operand vector rotated by the stored orientation with w zero, and leaves the
// state unchanged. All arithmetic runs on one shared multiply-accumulator, one
// bit-serial square root and one bit-serial divider under a sequencer, and a
// request is taken only while the sequencer is idle. A rotate runs two
// Hamilton products on the multiplier; a compose runs one Hamilton product,
// the sum of squares, the square root and four divisions, one per component.
// A zero product skips the root and divisions. A finished result sits in an
// output register, so the next request may enter while it waits.

module quaternion_orientation_unit
  import qou_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = CompWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  localparam int unsigned TdW = ((4 * COMP_WIDTH + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [TdW-1:0] s_axis_tdata_i,   // operand_x, operand_y, operand_z, operand_w
  input  logic           s_axis_tuser_i,   // func
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [TdW-1:0] m_axis_tdata_o    // out_x, out_y, out_z, out_w
);

  localparam int unsigned CW   = COMP_WIDTH;
  localparam int unsigned AccW = 2 * CW + 2;
  localparam int unsigned RtW  = AccW / 2;
  localparam int unsigned NumW = CW + FRAC_BITS;
  localparam int unsigned QW   = FRAC_BITS + 2;
  localparam int unsigned VW   = ((QW > CW) ? QW : CW) + 1;
  localparam logic signed [VW-1:0] CMaxV = VW'($signed({1'b0, {(CW-1){1'b1}}}));
  localparam logic signed [VW-1:0] CMinV = -CMaxV - VW'(1);
  localparam logic [QW-1:0] QMax = (QW'(1) << FRAC_BITS) + QW'(1);
  localparam logic [CW-1:0] WOne = (FRAC_BITS >= CW - 1) ?
                                   {1'b0, {(CW-1){1'b1}}} : (CW'(1) << FRAC_BITS);
  localparam logic [4:0] HmulLast = 5'd17;
  localparam logic [4:0] SqLast   = 5'd5;
  localparam logic [4:0] CapFirst = 5'd5;

  qou_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       func_q;
  logic       out_vld_q;

  logic [3:0][CW-1:0] op_q, orient_q, t_q, res_q, out_q;

  hmul_term_t term;
  mac_ctrl_t  mac_ctrl;
  logic       mac_sym;
  logic [CW-1:0] mac_a, mac_b, orient_rd, t_rd;
  logic [1:0]    orient_addr, t_addr, cap_idx;
  logic [4:0]    cap_off;
  logic [AccW-1:0]   mac_acc;
  logic signed [CW-1:0] mac_rnd;
  logic          capture, cap_t, cap_res, zero_res, div_wr, out_load, accept;
  logic          sqrt_start, sqrt_done, div_start, div_done;
  logic [RtW-1:0] root;
  logic [QW-1:0]  quot;
  logic           t_neg;
  logic [CW-1:0]  t_mag;
  logic [NumW-1:0] div_num;
  logic signed [VW-1:0] qv_s;
  logic [CW-1:0]  div_res;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Operand selection for the shared multiply-accumulator.
  always_comb begin
    term        = hmul_term(cnt_q[3:0]);
    orient_addr = (state_q == ST_HMUL1) ? term.b_idx : term.a_idx;
    orient_rd   = orient_q[orient_addr];
    if (state_q == ST_SQ) begin
      t_addr = cnt_q[1:0];
    end else if (state_q == ST_HMUL1) begin
      t_addr = term.a_idx;
    end else begin
      t_addr = idx_q;
    end
    t_rd = t_q[t_addr];
    case (state_q)
      ST_HMUL0: begin
        mac_a = orient_rd;
        mac_b = op_q[term.b_idx];
      end
      ST_HMUL1: begin
        mac_a = t_rd;
        mac_b = orient_rd;
      end
      default: begin
        mac_a = t_rd;
        mac_b = t_rd;
      end
    endcase
    mac_sym = (state_q == ST_HMUL0) && (func_q == FUNC_COMPOSE);
    cap_off = cnt_q - CapFirst;
    cap_idx = cap_off[3:2];
    capture = (cnt_q >= CapFirst) && (cnt_q[1:0] == 2'b01);
  end

  // Division operands: magnitude scaled up, half the divisor added for rounding.
  always_comb begin
    t_neg   = t_rd[CW-1];
    t_mag   = t_neg ? CW'(-t_rd) : t_rd;
    div_num = (NumW'(t_mag) << FRAC_BITS) + NumW'(root >> 1);
    qv_s    = VW'(quot);
    if (t_neg) begin
      qv_s = -qv_s;
    end
    if (qv_s > CMaxV) begin
      div_res = CMaxV[CW-1:0];
    end else if (qv_s < CMinV) begin
      div_res = CMinV[CW-1:0];
    end else begin
      div_res = qv_s[CW-1:0];
    end
  end

  // Sequencer: next state and per-cycle controls.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    mac_ctrl   = '0;
    cap_t      = 1'b0;
    cap_res    = 1'b0;
    zero_res   = 1'b0;
    div_wr     = 1'b0;
    out_load   = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_HMUL0;
          cnt_d   = '0;
          idx_d   = '0;
        end
      end
      ST_HMUL0, ST_HMUL1: begin
        mac_ctrl.valid = !cnt_q[4];
        mac_ctrl.first = (cnt_q[1:0] == 2'b00);
        mac_ctrl.neg   = term.neg ^ ((state_q == ST_HMUL1) && (term.b_idx != IDX_W));
        cap_t          = capture && (state_q == ST_HMUL0);
        cap_res        = capture && (state_q == ST_HMUL1);
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == HmulLast) begin
          cnt_d = '0;
          if (state_q == ST_HMUL1) begin
            state_d = ST_DONE;
          end else if (func_q == FUNC_ROTATE) begin
            state_d = ST_HMUL1;
          end else begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        mac_ctrl.valid = (cnt_q < 5'd4);
        mac_ctrl.first = (cnt_q == 5'd0);
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == SqLast) begin
          if (mac_acc == '0) begin
            zero_res = 1'b1;
            state_d  = ST_DONE;
          end else begin
            sqrt_start = 1'b1;
            state_d    = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          idx_d   = '0;
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          div_wr = 1'b1;
          if (idx_q == IDX_W) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      orient_q  <= {WOne, {(3*CW){1'b0}}};
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (out_load && (func_q == FUNC_COMPOSE)) begin
        orient_q <= res_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= s_axis_tuser_i;
      op_q[0]  <= s_axis_tdata_i[0*CW +: CW];
      op_q[1]  <= s_axis_tdata_i[1*CW +: CW];
      op_q[2]  <= s_axis_tdata_i[2*CW +: CW];
      // Rotation uses the operand as a pure vector.
      op_q[3]  <= (s_axis_tuser_i == FUNC_ROTATE) ? '0 : s_axis_tdata_i[3*CW +: CW];
    end
    if (cap_t) begin
      t_q[cap_idx] <= mac_rnd;
    end
    if (cap_res) begin
      res_q[cap_idx] <= (cap_idx == IDX_W) ? '0 : mac_rnd;
    end
    if (zero_res) begin
      res_q <= t_q;
    end
    if (div_wr) begin
      res_q[idx_q] <= div_res;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TdW'(out_q);

  qou_mac #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .sym_i  (mac_sym),
    .acc_o  (mac_acc),
    .rnd_o  (mac_rnd)
  );

  qou_isqrt #(
    .RAD_W (AccW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (mac_acc),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  qou_div #(
    .N_W (NumW),
    .D_W (RtW),
    .Q_W (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (root),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // The root is only taken of a non-zero sum of squares.
  a_sqrt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> (mac_acc != '0))
    else $error("square root started on a zero sum of squares");

  // A normalized component never exceeds one by more than a rounding step.
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (quot <= QMax))
    else $error("normalization quotient out of range");

  // A result appears only when the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside the hand-over state");

  // The orientation changes only at the end of a compose request.
  a_orient_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(orient_q) |-> $past((state_q == ST_DONE) && (func_q == FUNC_COMPOSE)))
    else $error("orientation changed outside a compose hand-over");

endmodule

// ----- hw/rtl/qou_mac.sv -----
`timescale 1ns / 1ps

module qou_mac
  import qou_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = CompWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mac_ctrl_t                         ctrl_i,
  input  logic signed [COMP_WIDTH-1:0]      a_i,
  input  logic signed [COMP_WIDTH-1:0]      b_i,
  input  logic                              sym_i,
  output logic        [2*COMP_WIDTH+1:0]    acc_o,
  output logic signed [COMP_WIDTH-1:0]      rnd_o
);

  localparam int unsigned AccW = 2 * COMP_WIDTH + 2;
  localparam logic signed [AccW-1:0] CMaxA =
    AccW'($signed({1'b0, {(COMP_WIDTH-1){1'b1}}}));
  localparam logic signed [AccW-1:0] CMinA = -CMaxA - AccW'(1);
  localparam logic signed [AccW-1:0] HalfA = AccW'(1) << (FRAC_BITS - 1);

  logic signed [2*COMP_WIDTH-1:0] prod_q;
  mac_ctrl_t                      pctrl_q;
  logic signed [AccW-1:0]         acc_q, acc_d;
  logic signed [AccW-1:0]         base, term, shifted, lo;

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctrl_q <= '0;
    end else begin
      pctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= a_i * b_i;
    end
  end

  // Accumulate stage: the sum of four products is kept exact.
  always_comb begin
    base  = pctrl_q.first ? '0 : acc_q;
    term  = AccW'(prod_q);
    acc_d = pctrl_q.neg ? base - term : base + term;
  end

  always_ff @(posedge clk_i) begin
    if (pctrl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // Round half up to the component format and saturate.
  always_comb begin
    shifted = (acc_q + HalfA) >>> FRAC_BITS;
    lo      = sym_i ? -CMaxA : CMinA;
    if (shifted > CMaxA) begin
      rnd_o = CMaxA[COMP_WIDTH-1:0];
    end else if (shifted < lo) begin
      rnd_o = lo[COMP_WIDTH-1:0];
    end else begin
      rnd_o = shifted[COMP_WIDTH-1:0];
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- hw/rtl/qou_isqrt.sv -----
`timescale 1ns / 1ps

module qou_isqrt
  import qou_pkg::*;
#(
  parameter int unsigned RAD_W = 2 * CompWidthDef + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAD_W-1:0]     rad_i,
  output logic                 done_o,
  output logic [RAD_W/2-1:0]   root_o
);

  localparam int unsigned RootW = RAD_W / 2;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned CntW  = $clog2(RootW + 1);

  logic [RAD_W-1:0] rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [RemW+1:0]  raw, trial;
  logic             take;

  // One root bit per cycle, two radicand bits brought down each step.
  always_comb begin
    raw   = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    take  = raw >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= take ? RemW'(raw - trial) : RemW'(raw);
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/qou_div.sv -----
`timescale 1ns / 1ps

module qou_div
  import qou_pkg::*;
#(
  parameter int unsigned N_W = CompWidthDef + FracBitsDef,
  parameter int unsigned D_W = CompWidthDef + 1,
  parameter int unsigned Q_W = FracBitsDef + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [N_W-1:0]  num_i,
  input  logic [D_W-1:0]  den_i,
  output logic            done_o,
  output logic [Q_W-1:0]  quot_o
);

  localparam int unsigned CntW = $clog2(Q_W + 1);

  logic [D_W-1:0] rem_q, den_q;
  logic [Q_W-1:0] quot_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [D_W:0]    raw;
  logic            take;

  // Restoring division, one quotient bit per cycle. The high numerator part
  // is known to lie below the divisor, so only Q_W steps are needed.
  always_comb begin
    raw  = {rem_q, quot_q[Q_W-1]};
    take = raw >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient register doubles as the shift line for the low numerator bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= D_W'(num_i[N_W-1:Q_W]);
      quot_q <= num_i[Q_W-1:0];
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= take ? D_W'(raw - {1'b0, den_q}) : D_W'(raw);
      quot_q <= {quot_q[Q_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
